// File: rtl/sequential_list_engine_top_defines.svh
// Assertion macros for the sequential list engine.
// Taken in by the top level; no other dependencies.
`ifndef SEQUENTIAL_LIST_ENGINE_TOP_DEFINES_SVH
`define SEQUENTIAL_LIST_ENGINE_TOP_DEFINES_SVH

`ifndef ASSERT_OFF
// prop must hold at every clock edge out of reset
`define SLE_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// cond must never be seen out of reset
`define SLE_ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define SLE_ASSERT(lbl, clk, rst_n, prop, msg)
`define SLE_ASSERT_NEVER(lbl, clk, rst_n, cond, msg)
`endif

`endif

// File: rtl/sle_pkg.sv
// Shared types for the sequential list engine: op and status codes,
// controller-to-datapath command and status structs. No dependencies.
package sle_pkg;

    typedef enum logic [2:0] {
        OP_CLEAR  = 3'd0,
        OP_INSERT = 3'd1,
        OP_DELETE = 3'd2,
        OP_GET    = 3'd3,
        OP_PRED   = 3'd4,
        OP_SUCC   = 3'd5
    } op_t;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_BAD_POS   = 3'd1,
        ST_FULL      = 3'd2,
        ST_NOT_FOUND = 3'd3,
        ST_NO_PRED   = 3'd4,
        ST_NO_SUCC   = 3'd5
    } status_t;

    // read address source
    typedef enum logic [2:0] {
        RD_INS_START = 3'd0,   // count-1
        RD_DEL_START = 3'd1,   // pos
        RD_GET       = 3'd2,   // pos-1
        RD_FIRST     = 3'd3,   // 0
        RD_DOWN      = 3'd4,   // ptr-1
        RD_UP        = 3'd5    // ptr+1
    } rd_sel_t;

    typedef enum logic [1:0] {
        WR_UP    = 2'd0,       // ptr+1 <- read word
        WR_DOWN  = 2'd1,       // ptr-1 <- read word
        WR_VALUE = 2'd2        // pos-1 <- request value
    } wr_sel_t;

    typedef enum logic [1:0] {
        CNT_HOLD  = 2'd0,
        CNT_CLEAR = 2'd1,
        CNT_INC   = 2'd2,
        CNT_DEC   = 2'd3
    } cnt_op_t;

    typedef enum logic [1:0] {
        RV_ZERO  = 2'd0,
        RV_RDATA = 2'd1,
        RV_PREV  = 2'd2
    } rv_sel_t;

    typedef struct packed {
        logic    load;
        logic    rd_en;
        rd_sel_t rd_sel;
        logic    wr_en;
        wr_sel_t wr_sel;
        cnt_op_t cnt_op;
        logic    cap_prev;
        logic    finish;
        status_t fin_status;
        rv_sel_t rv_sel;
    } cmd_t;

    typedef struct packed {
        op_t  op;
        logic ins_bad;
        logic pos_bad;
        logic full;
        logic ins_at_end;
        logic del_at_end;
        logic cnt_zero;
        logic ptr_at_pos;
        logic ptr_at_last;
        logic ptr_zero;
        logic hit;
    } sts_t;

    localparam int S_DATA_W = 40;
    localparam int M_DATA_W = 48;
    localparam int USER_W   = 3;

endpackage

// File: rtl/sle_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module sle_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// File: rtl/sle_ctrl.sv
// Controller state machine for the sequential list engine.
// Depends on sle_pkg; drives commands into sle_datapath.
module sle_ctrl
    import sle_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  logic s_tvalid,
    output logic s_tready,
    output logic m_tvalid,
    input  logic m_tready,
    input  sts_t sts,
    output cmd_t cmd
);

    typedef enum logic [6:0] {
        S_IDLE   = 7'b0000001,
        S_DECODE = 7'b0000010,
        S_SHIFT  = 7'b0000100,
        S_WRVAL  = 7'b0001000,
        S_GETW   = 7'b0010000,
        S_SRCH   = 7'b0100000,
        S_RESP   = 7'b1000000
    } state_t;

    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = (state_reg == S_RESP);

    always_comb begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    cmd.load   = 1'b1;
                    state_next = S_DECODE;
                end
            end
            S_DECODE: begin
                case (sts.op)
                    OP_CLEAR: begin
                        cmd.cnt_op = CNT_CLEAR;
                        cmd.finish = 1'b1;
                        state_next = S_RESP;
                    end
                    OP_INSERT: begin
                        if (sts.ins_bad) begin
                            cmd.finish     = 1'b1;
                            cmd.fin_status = ST_BAD_POS;
                            state_next     = S_RESP;
                        end else if (sts.full) begin
                            cmd.finish     = 1'b1;
                            cmd.fin_status = ST_FULL;
                            state_next     = S_RESP;
                        end else if (sts.ins_at_end) begin
                            state_next = S_WRVAL;
                        end else begin
                            cmd.rd_en  = 1'b1;
                            cmd.rd_sel = RD_INS_START;
                            state_next = S_SHIFT;
                        end
                    end
                    OP_DELETE: begin
                        if (sts.pos_bad) begin
                            cmd.finish     = 1'b1;
                            cmd.fin_status = ST_BAD_POS;
                            state_next     = S_RESP;
                        end else if (sts.del_at_end) begin
                            cmd.cnt_op = CNT_DEC;
                            cmd.finish = 1'b1;
                            state_next = S_RESP;
                        end else begin
                            cmd.rd_en  = 1'b1;
                            cmd.rd_sel = RD_DEL_START;
                            state_next = S_SHIFT;
                        end
                    end
                    OP_GET: begin
                        if (sts.pos_bad) begin
                            cmd.finish     = 1'b1;
                            cmd.fin_status = ST_BAD_POS;
                            state_next     = S_RESP;
                        end else begin
                            cmd.rd_en  = 1'b1;
                            cmd.rd_sel = RD_GET;
                            state_next = S_GETW;
                        end
                    end
                    OP_PRED, OP_SUCC: begin
                        if (sts.cnt_zero) begin
                            cmd.finish     = 1'b1;
                            cmd.fin_status = ST_NOT_FOUND;
                            state_next     = S_RESP;
                        end else begin
                            cmd.rd_en  = 1'b1;
                            cmd.rd_sel = RD_FIRST;
                            state_next = S_SRCH;
                        end
                    end
                    default: begin
                        // unused op codes: no-op, ok
                        cmd.finish = 1'b1;
                        state_next = S_RESP;
                    end
                endcase
            end
            S_SHIFT: begin
                // read data belongs to ptr; move it one slot over
                cmd.wr_en = 1'b1;
                if (sts.op == OP_INSERT) begin
                    cmd.wr_sel = WR_UP;
                    if (sts.ptr_at_pos) begin
                        state_next = S_WRVAL;
                    end else begin
                        cmd.rd_en  = 1'b1;
                        cmd.rd_sel = RD_DOWN;
                    end
                end else begin
                    cmd.wr_sel = WR_DOWN;
                    if (sts.ptr_at_last) begin
                        cmd.cnt_op = CNT_DEC;
                        cmd.finish = 1'b1;
                        state_next = S_RESP;
                    end else begin
                        cmd.rd_en  = 1'b1;
                        cmd.rd_sel = RD_UP;
                    end
                end
            end
            S_WRVAL: begin
                cmd.wr_en  = 1'b1;
                cmd.wr_sel = WR_VALUE;
                cmd.cnt_op = CNT_INC;
                cmd.finish = 1'b1;
                state_next = S_RESP;
            end
            S_GETW: begin
                cmd.finish = 1'b1;
                cmd.rv_sel = RV_RDATA;
                state_next = S_RESP;
            end
            S_SRCH: begin
                cmd.cap_prev = 1'b1;
                if (sts.hit) begin
                    if (sts.op == OP_PRED) begin
                        cmd.finish = 1'b1;
                        state_next = S_RESP;
                        if (sts.ptr_zero) begin
                            cmd.fin_status = ST_NO_PRED;
                        end else begin
                            cmd.rv_sel = RV_PREV;
                        end
                    end else if (sts.ptr_at_last) begin
                        cmd.finish     = 1'b1;
                        cmd.fin_status = ST_NO_SUCC;
                        state_next     = S_RESP;
                    end else begin
                        // fetch the successor, reuse the get wait
                        cmd.rd_en  = 1'b1;
                        cmd.rd_sel = RD_UP;
                        state_next = S_GETW;
                    end
                end else if (sts.ptr_at_last) begin
                    cmd.finish     = 1'b1;
                    cmd.fin_status = ST_NOT_FOUND;
                    state_next     = S_RESP;
                end else begin
                    cmd.rd_en  = 1'b1;
                    cmd.rd_sel = RD_UP;
                end
            end
            S_RESP: begin
                if (m_tready) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

// File: rtl/sle_datapath.sv
// Datapath for the sequential list engine: request registers, entry count,
// walk pointer, list store and result word. Depends on sle_pkg and sle_ram.
module sle_datapath
    import sle_pkg::*;
#(
    parameter int CAPACITY = 128
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic [S_DATA_W-1:0] s_tdata,   // [7:0] position, [39:8] value
    input  logic [USER_W-1:0]   s_tuser,   // [2:0] op
    input  cmd_t                cmd,
    output sts_t                sts,
    output logic [M_DATA_W-1:0] m_tdata,   // [31:0] result_value, [39:32] count,
                                           // [40] is_empty, [47:41] zero
    output logic [USER_W-1:0]   m_tuser    // [2:0] status
);

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int XW = (CW > 8) ? CW : 8;
    localparam int PW = XW + 1;

    op_t               op_reg;
    logic [7:0]        pos_reg;
    logic signed [31:0] val_reg;
    logic [CW-1:0]     count_reg, count_next;
    logic [AW-1:0]     ptr_reg, ptr_next;
    logic [31:0]       prev_reg;
    status_t           res_status_reg;
    logic signed [31:0] res_value_reg;
    logic [7:0]        res_count_reg;
    logic              res_empty_reg;

    logic [PW-1:0]     pos_w, cnt_w, pos_m1, cnt_m1, cnt_p1;
    logic [XW-1:0]     cnt_ext;
    logic [AW-1:0]     rd_addr, wr_addr;
    logic [31:0]       rd_data, wr_data, rv;

    assign pos_w  = PW'(pos_reg);
    assign cnt_w  = PW'(count_reg);
    assign pos_m1 = pos_w - PW'(1);
    assign cnt_m1 = cnt_w - PW'(1);
    assign cnt_p1 = cnt_w + PW'(1);

    always_comb begin
        case (cmd.rd_sel)
            RD_INS_START: rd_addr = cnt_m1[AW-1:0];
            RD_DEL_START: rd_addr = pos_w[AW-1:0];
            RD_GET:       rd_addr = pos_m1[AW-1:0];
            RD_FIRST:     rd_addr = '0;
            RD_DOWN:      rd_addr = ptr_reg - AW'(1);
            RD_UP:        rd_addr = ptr_reg + AW'(1);
            default:      rd_addr = '0;
        endcase
    end

    always_comb begin
        case (cmd.wr_sel)
            WR_UP:    wr_addr = ptr_reg + AW'(1);
            WR_DOWN:  wr_addr = ptr_reg - AW'(1);
            WR_VALUE: wr_addr = pos_m1[AW-1:0];
            default:  wr_addr = pos_m1[AW-1:0];
        endcase
    end

    assign wr_data  = (cmd.wr_sel == WR_VALUE) ? val_reg : rd_data;
    assign ptr_next = cmd.rd_en ? rd_addr : ptr_reg;

    always_comb begin
        case (cmd.cnt_op)
            CNT_CLEAR: count_next = '0;
            CNT_INC:   count_next = count_reg + CW'(1);
            CNT_DEC:   count_next = count_reg - CW'(1);
            default:   count_next = count_reg;
        endcase
    end

    always_comb begin
        case (cmd.rv_sel)
            RV_RDATA: rv = rd_data;
            RV_PREV:  rv = prev_reg;
            default:  rv = '0;
        endcase
    end

    assign cnt_ext = XW'(count_next);

    sle_ram #(
        .WIDTH (32),
        .DEPTH (CAPACITY)
    ) u_store (
        .clk     (aclk),
        .wr_en   (cmd.wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (cmd.rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        ptr_reg <= ptr_next;
        if (cmd.load) begin
            op_reg  <= op_t'(s_tuser[2:0]);
            pos_reg <= s_tdata[7:0];
            val_reg <= s_tdata[39:8];
        end
        if (cmd.cap_prev) begin
            prev_reg <= rd_data;
        end
        if (cmd.finish) begin
            res_status_reg <= cmd.fin_status;
            res_value_reg  <= rv;
            res_count_reg  <= cnt_ext[7:0];
            res_empty_reg  <= (count_next == '0);
        end
    end

    always_comb begin
        sts.op          = op_reg;
        sts.ins_bad     = (pos_reg == 8'd0) || (pos_w > cnt_p1);
        sts.pos_bad     = (pos_reg == 8'd0) || (pos_w > cnt_w);
        sts.full        = (count_reg == CW'(CAPACITY));
        sts.ins_at_end  = (pos_w == cnt_p1);
        sts.del_at_end  = (pos_w == cnt_w);
        sts.cnt_zero    = (count_reg == '0);
        sts.ptr_at_pos  = (ptr_reg == pos_m1[AW-1:0]);
        sts.ptr_at_last = (ptr_reg == cnt_m1[AW-1:0]);
        sts.ptr_zero    = (ptr_reg == '0);
        sts.hit         = (rd_data == val_reg);
    end

    assign m_tdata = {7'd0, res_empty_reg, res_count_reg, res_value_reg};
    assign m_tuser = res_status_reg;

endmodule

// File: rtl/sequential_list_engine_top.sv
// Sequential list engine: a packed list of signed 32-bit entries, up to
// CAPACITY of them, held in one RAM with an entry count.
// Input channel s_*: one request word; s_tuser carries the op (clear,
// insert, delete, get, predecessor, successor), s_tdata position and value.
// Result channel m_*: one word per request; m_tuser carries the status,
// m_tdata the value read, the entry count after the request and an empty flag.
// One request is in flight at a time: s_tready is high only while idle.
// Clear, delete of the last entry and any refused request finish straight from
// decode; get reads one word; insert and delete first move the later entries
// over by one slot; predecessor/successor scan entries (a successor reads one more).
// The longest requests are the shift and search walks over the store's single
// read port, one entry per cycle.
// The controller returns to idle after the result is taken.
// Reset empties the list; stored words are left as they are.
// A stalled receiver holds the result in its output register, and no new
// request is taken until the word has been accepted.
// Depends on sle_pkg, sle_ctrl, sle_datapath, sle_ram and the defines header.
`include "sequential_list_engine_top_defines.svh"

module sequential_list_engine_top
    import sle_pkg::*;
#(
    parameter int CAPACITY = 128
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [S_DATA_W-1:0] s_tdata,   // [7:0] position, [39:8] value
    input  logic [USER_W-1:0]   s_tuser,   // [2:0] op
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [M_DATA_W-1:0] m_tdata,   // [31:0] result_value, [39:32] count,
                                           // [40] is_empty, [47:41] zero
    output logic [USER_W-1:0]   m_tuser    // [2:0] status
);

    cmd_t cmd;
    sts_t sts;

    sle_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    sle_datapath #(
        .CAPACITY (CAPACITY)
    ) u_dp (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .cmd     (cmd),
        .sts     (sts),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser)
    );

    // one request at a time: never ready while a result is pending
    `SLE_ASSERT_NEVER(a_no_overlap, aclk, aresetn, s_tready && m_tvalid, "ready with result pending")
    // an accepted word makes the block busy on the next cycle
    `SLE_ASSERT(a_busy_after_accept, aclk, aresetn, (s_tvalid && s_tready) |=> (!s_tready && !m_tvalid), "not busy after accept")
    // refused requests carry a zero value
    `SLE_ASSERT(a_fail_zero_value, aclk, aresetn, (m_tvalid && (m_tuser != ST_OK)) |-> (m_tdata[31:0] == 32'd0), "nonzero value on failed request")
    // the list store is never written while a result waits
    `SLE_ASSERT_NEVER(a_no_write_in_resp, aclk, aresetn, m_tvalid && cmd.wr_en, "store write during response")

endmodule

// File: tb/sequential_list_engine_top_tb.sv
`timescale 1ns / 100ps
// Testbench for sequential_list_engine_top: directed and random list requests,
// each result word checked against a mirror of the list under varied back-pressure.
// Depends on sle_pkg and the sequential_list_engine_top RTL.
module sequential_list_engine_top_tb;
    import sle_pkg::*;

    localparam int LIST_CAP     = 128;
    localparam int STALL_LIMIT  = 4000;
    localparam int RANDOM_ITEMS = 460;

    typedef struct packed {
        status_t     status;
        logic [31:0] value;
        logic [7:0]  count;
        logic        empty;
    } list_reply_t;

    // Mirror of the list contents; predicts one reply per request.
    class list_mirror;
        logic [31:0] entries [LIST_CAP];
        int          entry_cnt;
        int          errors;
        list_reply_t pending[$];

        function new();
            entry_cnt = 0;
            errors    = 0;
        endfunction

        function int find_first(logic [31:0] key);
            int k;
            for (k = 0; k < entry_cnt; k++) begin
                if (entries[k] == key) break;
            end
            return k;
        endfunction

        function logic [31:0] pick_entry();
            return entries[$urandom_range(entry_cnt - 1)];
        endfunction

        function void note_request(op_t op, logic [7:0] pos, logic [31:0] val);
            list_reply_t r;
            int p;
            int k;
            int hit;
            p = pos;
            r.status = ST_OK;
            r.value  = '0;
            case (op)
                OP_CLEAR: entry_cnt = 0;
                OP_INSERT: begin
                    if (p < 1 || p > entry_cnt + 1) begin
                        r.status = ST_BAD_POS;
                    end else if (entry_cnt >= LIST_CAP) begin
                        r.status = ST_FULL;
                    end else begin
                        for (k = entry_cnt; k > p - 1; k--) entries[k] = entries[k - 1];
                        entries[p - 1] = val;
                        entry_cnt++;
                    end
                end
                OP_DELETE: begin
                    if (p < 1 || p > entry_cnt) begin
                        r.status = ST_BAD_POS;
                    end else begin
                        for (k = p - 1; k + 1 < entry_cnt; k++) entries[k] = entries[k + 1];
                        entry_cnt--;
                    end
                end
                OP_GET: begin
                    if (p < 1 || p > entry_cnt) r.status = ST_BAD_POS;
                    else r.value = entries[p - 1];
                end
                OP_PRED: begin
                    hit = find_first(val);
                    if (hit >= entry_cnt) r.status = ST_NOT_FOUND;
                    else if (hit == 0) r.status = ST_NO_PRED;
                    else r.value = entries[hit - 1];
                end
                OP_SUCC: begin
                    hit = find_first(val);
                    if (hit >= entry_cnt) r.status = ST_NOT_FOUND;
                    else if (hit + 1 == entry_cnt) r.status = ST_NO_SUCC;
                    else r.value = entries[hit + 1];
                end
                default: ;
            endcase
            r.count = entry_cnt[7:0];
            r.empty = (entry_cnt == 0);
            pending.push_back(r);
        endfunction

        function void check_reply(logic [USER_W-1:0] user, logic [M_DATA_W-1:0] data);
            list_reply_t want;
            if (pending.size() == 0) begin
                $display("%0t: result word with nothing pending: status %0d data %h",
                         $time, user, data);
                errors++;
                return;
            end
            want = pending.pop_front();
            if (user !== want.status) begin
                $display("%0t: status expected %0d, got %0d", $time, want.status, user);
                errors++;
            end
            if (data[31:0] !== want.value) begin
                $display("%0t: value expected %h, got %h", $time, want.value, data[31:0]);
                errors++;
            end
            if (data[39:32] !== want.count) begin
                $display("%0t: count expected %0d, got %0d", $time, want.count, data[39:32]);
                errors++;
            end
            if (data[40] !== want.empty) begin
                $display("%0t: empty expected %b, got %b", $time, want.empty, data[40]);
                errors++;
            end
            if (data[47:41] !== '0) begin
                $display("%0t: pad bits expected 0, got %h", $time, data[47:41]);
                errors++;
            end
        endfunction
    endclass

    logic                aclk = 1'b0;
    logic                aresetn = 1'b0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [S_DATA_W-1:0] s_tdata = '0;
    logic [USER_W-1:0]   s_tuser = '0;
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [M_DATA_W-1:0] m_tdata;
    logic [USER_W-1:0]   m_tuser;

    list_mirror mirror = new();
    int         src_idle_pct = 0;
    int         snk_stall_pct = 0;
    int         quiet_cycles = 0;
    bit         filling = 1'b1;

    sequential_list_engine_top #(.CAPACITY(LIST_CAP)) u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) mirror.check_reply(m_tuser, m_tdata);
        m_tready <= ($urandom_range(99) >= snk_stall_pct);
    end

    // ends the run if neither channel moves a word for too long
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("sequential_list_engine_top regression: fail");
                $finish;
            end
        end
    end

    task automatic send_request(op_t op, logic [7:0] pos, logic [31:0] val);
        while ($urandom_range(99) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {val, pos};
        do @(posedge aclk); while (!s_tready);
        mirror.note_request(op, pos, val);
    endtask

    // mostly a valid position in 1..top, else zero, 255 or past the end
    function automatic logic [7:0] pick_pos(int top);
        if (top > 0 && $urandom_range(99) < 85) return 8'($urandom_range(top, 1));
        case ($urandom_range(2))
            0:       return 8'd0;
            1:       return 8'd255;
            default: return 8'($urandom_range(255, top + 1));
        endcase
    endfunction

    // stored values make duplicates, the small pool makes repeats
    function automatic logic [31:0] pick_value(int hit_pct);
        int r;
        r = $urandom_range(99);
        if (mirror.entry_cnt > 0 && r < hit_pct) return mirror.pick_entry();
        if (r < hit_pct + 20) return 32'($urandom_range(7)) - 32'd3;
        return $urandom;
    endfunction

    task automatic run_random(int n);
        int   r;
        int   cnt;
        op_t  op;
        for (int i = 0; i < n; i++) begin
            cnt = mirror.entry_cnt;
            if (cnt == 0) filling = 1'b1;
            else if (cnt == LIST_CAP && $urandom_range(3) == 0) filling = 1'b0;
            r = $urandom_range(99);
            if (filling) begin
                op = r < 60 ? OP_INSERT : r < 70 ? OP_DELETE : r < 82 ? OP_GET :
                     r < 91 ? OP_PRED : OP_SUCC;
            end else begin
                op = r < 1 ? OP_CLEAR : r < 50 ? OP_DELETE : r < 62 ? OP_INSERT :
                     r < 74 ? OP_GET : r < 86 ? OP_PRED : OP_SUCC;
            end
            case (op)
                OP_INSERT: send_request(op, pick_pos(cnt + 1), pick_value(25));
                OP_DELETE, OP_GET: send_request(op, pick_pos(cnt), $urandom);
                OP_PRED, OP_SUCC: send_request(op, 8'($urandom), pick_value(70));
                default: send_request(op, 8'($urandom), $urandom);
            endcase
        end
    endtask

    initial begin
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // empty list, bad positions, signed extremes, duplicates, list ends
        send_request(OP_GET, 8'd1, 32'd0);
        send_request(OP_DELETE, 8'd1, 32'd0);
        send_request(OP_PRED, 8'd0, 32'd5);
        send_request(OP_SUCC, 8'd0, 32'd5);
        send_request(OP_INSERT, 8'd0, 32'd9);
        send_request(OP_INSERT, 8'd2, 32'd9);
        send_request(OP_INSERT, 8'd1, 32'h7FFF_FFFF);
        send_request(OP_INSERT, 8'd2, 32'h8000_0000);
        send_request(OP_INSERT, 8'd1, 32'hFFFF_FFFF);
        send_request(OP_INSERT, 8'd2, 32'd5);
        send_request(OP_INSERT, 8'd5, 32'd5);
        send_request(OP_GET, 8'd5, 32'd0);
        send_request(OP_GET, 8'd6, 32'd0);
        send_request(OP_GET, 8'd255, 32'd0);
        send_request(OP_PRED, 8'd0, 32'hFFFF_FFFF);
        send_request(OP_PRED, 8'd0, 32'd5);
        send_request(OP_SUCC, 8'd0, 32'd5);
        send_request(OP_PRED, 8'd0, 32'd0);
        send_request(OP_DELETE, 8'd5, 32'd0);
        send_request(OP_SUCC, 8'd0, 32'h8000_0000);
        send_request(OP_DELETE, 8'd1, 32'd0);
        send_request(OP_DELETE, 8'd0, 32'd0);
        send_request(OP_CLEAR, 8'd0, 32'd0);
        send_request(OP_GET, 8'd1, 32'd0);
        send_request(OP_INSERT, 8'd1, 32'd0);
        send_request(OP_DELETE, 8'd1, 32'd0);

        run_random(RANDOM_ITEMS);
        src_idle_pct  = 59;
        run_random(RANDOM_ITEMS);
        src_idle_pct  = 0;
        snk_stall_pct = 59;
        run_random(RANDOM_ITEMS);
        src_idle_pct  = 38;
        snk_stall_pct = 38;
        run_random(RANDOM_ITEMS);
        s_tvalid <= 1'b0;

        while (mirror.pending.size() != 0) @(posedge aclk);
        repeat (LIST_CAP + 8) @(posedge aclk);
        if (mirror.errors == 0) begin
            $display("sequential_list_engine_top regression: pass");
        end else begin
            $display("sequential_list_engine_top regression: fail");
        end
        $finish;
    end

endmodule
